// ----- rtl/dcc_pkg.sv -----
`timescale 1ns / 1ps
package dcc_pkg;

  typedef enum logic [4:0] {
    S_LOAD,
    S_SUM,
    S_SUMSQ,
    S_DENXY,
    S_DEN,
    S_DEN_W,
    S_MAC,
    S_NUM1,
    S_NUM2,
    S_PEAK,
    S_TGT_W,
    S_BS,
    S_BS_SQ,
    S_BS_W,
    S_THR,
    S_THR_W,
    S_DONE
  } state_t;

  localparam int unsigned FRAC_W = 15;
  localparam int unsigned Q_W    = 16;

endpackage

// ----- rtl/dcc_mul.sv -----
`timescale 1ns / 1ps
module dcc_mul #(
  parameter int unsigned W = 40
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           busy,
  output logic           done,
  output logic [2*W-1:0] prod
);
  // shift-add multiplier, one multiplier bit per cycle, stops when no bits are left
  logic           run;
  logic [2*W-1:0] acc;
  logic [2*W-1:0] ash;
  logic [W-1:0]   bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && bsh == '0) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= {{W{1'b0}}, a};
      bsh <= b;
    end else if (run && bsh != '0) begin
      if (bsh[0]) begin
        acc <= acc + ash;
      end
      ash <= ash << 1;
      bsh <= bsh >> 1;
    end
  end

  assign busy = run;
  assign done = run && (bsh == '0);
  assign prod = acc;

endmodule

// ----- rtl/digest_circular_cross_correlation.sv -----
`timescale 1ns / 1ps
// Circular cross-correlation of two byte digests. Each input item carries one
// coefficient of each digest; pairs beyond MAX_LEN are dropped, and the item
// with last_item set closes the load and starts the computation. The input
// stalls until the result has been placed in the output register. For n
// loaded pairs the computation forms the sums, the denominator product, the
// shift scan (one memory read of each digest and one 8x8 multiply-accumulate
// per cycle), then up to 16 search steps of the shift-add multiplier to find
// the truncated Q1.15 peak and one more multiply for the threshold check. The
// serial multiplier is shared by the denominator, the search and the
// threshold check. The peak is the largest Pearson correlation over all
// shifts, clamped at zero; is_match is set when it strictly exceeds
// match_threshold (Q1.15, signed). A constant digest gives a peak of zero.
// The threshold is written through its own valid/ready port, always ready,
// and should only change while idle.
module digest_circular_cross_correlation #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  x_coeff,
  input  logic [7:0]  y_coeff,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] peak_correlation,
  output logic        is_match,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] match_threshold
);
  import dcc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned S1_W  = 8 + CNT_W;         // sum of bytes
  localparam int unsigned S2_W  = 16 + CNT_W;        // sum of byte products
  localparam int unsigned DX_W  = CNT_W + S2_W;      // n*sum terms
  localparam int unsigned DEN_W = 2 * DX_W;
  localparam int unsigned A_W   = DX_W + FRAC_W;     // scaled peak numerator
  localparam int unsigned MUL_W = DEN_W;
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

  state_t state, state_next;

  // digest storage, one read per digest per cycle
  logic [7:0] x_mem [MAX_LEN];
  logic [7:0] y_mem [MAX_LEN];
  logic [7:0] x_rd, y_rd;
  logic [IDX_W-1:0] ra_x, ra_y;
  logic             we;

  // control counters
  logic [CNT_W-1:0] cnt;        // pairs loaded so far
  logic [CNT_W-1:0] n;          // length of the closed load
  logic [CNT_W-1:0] ia;         // issue index
  logic [CNT_W-1:0] d;          // current shift
  logic [IDX_W-1:0] j;          // second digest index for this shift
  logic [IDX_W-1:0] j_start;
  logic             rd_vld;
  logic             issuing;

  // datapath
  logic [S1_W-1:0]  sx, sy;
  logic [S2_W-1:0]  sxx, syy, sxy;
  logic [DX_W-1:0]  nsxx, nsyy, sxsx, sysy, sxsy, nsxy;
  logic [DX_W-1:0]  denx, deny;
  logic [DEN_W-1:0] den;
  logic [DX_W-1:0]  best;
  logic signed [DX_W:0] num;
  logic [2*MUL_W-1:0] target;
  logic [Q_W-1:0]   lo, hi, mid;
  logic [Q_W:0]     mid_sum;
  logic [Q_W-1:0]   peak;
  logic             match;
  logic [16:0]      thr;

  // shared multiplier
  logic               mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_prod;
  logic [A_W-1:0]     a_val;
  logic [Q_W-1:0]     t_val;

  dcc_mul #(.W(MUL_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 17'd29491;
    end else if (cfg_valid && cfg_ready) begin
      thr <= match_threshold;
    end
  end

  assign issuing = (ia < n);
  assign a_val   = {best, {FRAC_W{1'b0}}};
  assign t_val   = thr[Q_W-1:0];
  assign mid_sum = {1'b0, lo} + {1'b0, hi} + 1'b1;
  assign num     = $signed({1'b0, nsxy}) - $signed({1'b0, sxsy});

  // memories
  assign we   = (state == S_LOAD) && in_valid && !in_stall && (cnt < CNT_W'(MAX_LEN));
  assign ra_x = ia[IDX_W-1:0];
  assign ra_y = (state == S_MAC) ? j : ia[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      x_mem[cnt[IDX_W-1:0]] <= x_coeff;
      y_mem[cnt[IDX_W-1:0]] <= y_coeff;
    end
    x_rd <= x_mem[ra_x];
    y_rd <= y_mem[ra_y];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (in_valid && !in_stall && last_item) state_next = S_SUM;
      S_SUM:   if (!issuing && !rd_vld) state_next = S_SUMSQ;
      S_SUMSQ: state_next = S_DENXY;
      S_DENXY: state_next = S_DEN;
      S_DEN:   state_next = S_DEN_W;
      S_DEN_W: begin
        if (mul_done) begin
          state_next = (mul_prod[DEN_W-1:0] == '0) ? S_THR : S_MAC;
        end
      end
      S_MAC:   if (!issuing && !rd_vld) state_next = S_NUM1;
      S_NUM1:  state_next = S_NUM2;
      S_NUM2:  state_next = (d + 1'b1 == n) ? S_PEAK : S_MAC;
      S_PEAK:  state_next = (best == '0) ? S_THR : S_TGT_W;
      S_TGT_W: if (mul_done) state_next = S_BS;
      S_BS:    state_next = (lo < hi) ? S_BS_SQ : S_THR;
      S_BS_SQ: state_next = S_BS_W;
      S_BS_W:  if (mul_done) state_next = S_BS;
      S_THR: begin
        if (thr[16] || best == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_THR_W;
        end
      end
      S_THR_W: if (mul_done) state_next = S_DONE;
      S_DONE:  if (!out_valid || !out_stall) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall  = (state != S_LOAD);
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_DEN: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(denx);
        mul_b     = MUL_W'(deny);
      end
      S_PEAK: begin
        mul_start = (best != '0);
        mul_a     = MUL_W'(a_val);
        mul_b     = MUL_W'(a_val);
      end
      S_BS_SQ: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'({{Q_W{1'b0}}, mid} * {{Q_W{1'b0}}, mid});
        mul_b     = MUL_W'(den);
      end
      S_THR: begin
        mul_start = !thr[16] && (best != '0);
        mul_a     = MUL_W'({{Q_W{1'b0}}, t_val} * {{Q_W{1'b0}}, t_val});
        mul_b     = MUL_W'(den);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= ((state == S_SUM) || (state == S_MAC)) && issuing;
      if (state == S_LOAD && in_valid && !in_stall) begin
        if (last_item) begin
          cnt <= '0;
        end else if (cnt < CNT_W'(MAX_LEN)) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (in_valid && !in_stall && last_item) begin
          n    <= (cnt < CNT_W'(MAX_LEN)) ? cnt + 1'b1 : cnt;
          ia   <= '0;
          sx   <= '0;
          sy   <= '0;
          sxx  <= '0;
          syy  <= '0;
          best <= '0;
          peak <= '0;
        end
      end
      S_SUM: begin
        if (issuing) ia <= ia + 1'b1;
        if (rd_vld) begin
          sx  <= sx + S1_W'(x_rd);
          sy  <= sy + S1_W'(y_rd);
          sxx <= sxx + S2_W'({8'd0, x_rd} * {8'd0, x_rd});
          syy <= syy + S2_W'({8'd0, y_rd} * {8'd0, y_rd});
        end
      end
      S_SUMSQ: begin
        nsxx <= DX_W'(n) * DX_W'(sxx);
        nsyy <= DX_W'(n) * DX_W'(syy);
        sxsx <= DX_W'(sx) * DX_W'(sx);
        sysy <= DX_W'(sy) * DX_W'(sy);
        sxsy <= DX_W'(sx) * DX_W'(sy);
      end
      S_DENXY: begin
        denx <= nsxx - sxsx;
        deny <= nsyy - sysy;
      end
      S_DEN_W: begin
        if (mul_done) begin
          den     <= mul_prod[DEN_W-1:0];
          d       <= '0;
          ia      <= '0;
          j       <= '0;
          j_start <= '0;
          sxy     <= '0;
        end
      end
      S_MAC: begin
        if (issuing) begin
          ia <= ia + 1'b1;
          j  <= (j == IDX_W'(n - 1'b1)) ? '0 : j + 1'b1;
        end
        if (rd_vld) sxy <= sxy + S2_W'({8'd0, x_rd} * {8'd0, y_rd});
      end
      S_NUM1: begin
        nsxy <= DX_W'(n) * DX_W'(sxy);
      end
      S_NUM2: begin
        if (num > $signed({1'b0, best})) best <= num[DX_W-1:0];
        // next shift starts one place further back in the second digest
        d       <= d + 1'b1;
        ia      <= '0;
        sxy     <= '0;
        j       <= (j_start == '0) ? IDX_W'(n - 1'b1) : j_start - 1'b1;
        j_start <= (j_start == '0) ? IDX_W'(n - 1'b1) : j_start - 1'b1;
      end
      S_TGT_W: begin
        if (mul_done) begin
          target <= mul_prod;
          lo     <= '0;
          hi     <= Q_ONE;
        end
      end
      S_BS: begin
        mid <= mid_sum[Q_W:1];
        if (!(lo < hi)) peak <= lo;
      end
      S_BS_W: begin
        if (mul_done) begin
          if (mul_prod <= target) lo <= mid;
          else                    hi <= mid - 1'b1;
        end
      end
      S_THR: begin
        if (thr[16])          match <= 1'b1;
        else if (best == '0)  match <= 1'b0;
      end
      S_THR_W: begin
        if (mul_done) match <= (target > mul_prod);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      peak_correlation <= peak;
      is_match         <= match;
    end
  end

  // checks
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result appeared without a finished computation");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_LEN))
    else $error("load count beyond depth");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_correlation <= Q_ONE)
    else $error("peak above one");

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

endmodule
